[sv/fbpa_pkg.sv]
// shared widths, codes and types for the fixed block pool allocator
`timescale 1ns / 1ps

package fbpa_pkg;

    // fixed field widths
    localparam int ADDR_W    = 32;
    localparam int BSIZE_W   = 16;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;

    // iterative divider: one quotient bit per step
    localparam int DIV_STEPS = ADDR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // smallest legal block size in bytes
    localparam logic [BSIZE_W-1:0] MIN_BLOCK_SIZE = BSIZE_W'(4);

    // commands
    localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_POOL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_IN_USE       = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_DELETE = 2'd3;

    // configuration reset values
    localparam logic [ADDR_W-1:0]  RST_BASE_ADDRESS = 32'd0;
    localparam logic [ADDR_W-1:0]  RST_POOL_LENGTH  = 32'd16384;
    localparam logic [BSIZE_W-1:0] RST_BLOCK_SIZE   = 16'd16;

    // divider result handed back to the sequencer
    typedef struct packed {
        logic               done;
        logic [ADDR_W-1:0]  quotient;
        logic [BSIZE_W-1:0] remainder;
    } div_res_t;

endpackage

[sv/fbpa_ram.sv]
// generic single write, single read port ram with registered read data
`timescale 1ns / 1ps

module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/fbpa_div.sv]
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module fbpa_div
    import fbpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [ADDR_W-1:0]  dividend,
    input  logic [BSIZE_W-1:0] divisor,
    output div_res_t           res
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0]    quo_reg, quo_next;
    logic [BSIZE_W-1:0]   rem_reg, rem_next;
    logic [BSIZE_W-1:0]   dvsr_reg, dvsr_next;

    logic [BSIZE_W:0] shifted;
    logic [BSIZE_W:0] diff;
    logic             fits;

    // one shift and trial subtract
    assign shifted = {rem_reg, quo_reg[ADDR_W-1]};
    assign diff    = shifted - {1'b0, dvsr_reg};
    assign fits    = (shifted >= {1'b0, dvsr_reg});

    // step control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[ADDR_W-2:0], fits};
            rem_next = fits ? diff[BSIZE_W-1:0] : shifted[BSIZE_W-1:0];
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

[sv/fixed_block_pool_allocator.sv]
// fixed block pool allocator: command sequencer, free list and result register
// get reads the head link via S_GET_RD; delete and entry refusals go straight to S_RESP
// create runs the shared 32-step divider, then S_LINK writes one link memory entry per cycle
// release divides too, refuses a bad offset, else walks the free list and appends the block
// one command at a time; the next one is taken while the last result waits to be taken
// reset: asynchronous, no pool, empty free list; the link memory is not cleared and is
// filled by create
`timescale 1ns / 1ps

module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024,
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1),
    localparam int OUT_BITS = STATUS_W + ADDR_W + 2 * CNT_W,
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // command stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [ADDR_W-1:0]      s_tdata,   // [31:0] buffer_address
    input  logic [CMD_W-1:0]       s_tuser,   // [1:0] command
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // status, block_address, free_blocks,
                                              // used_blocks, zero fill
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data
);

    localparam int RAM_AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int OUT_PAD = OUT_TDATA_W - OUT_BITS;
    localparam logic [CNT_W-1:0] NULL_IDX = CNT_W'(MAX_BLOCKS);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIV      = 4'd1;
    localparam logic [3:0] S_LINK     = 4'd2;
    localparam logic [3:0] S_GET_RD   = 4'd3;
    localparam logic [3:0] S_WALK     = 4'd4;
    localparam logic [3:0] S_WALK_RD  = 4'd5;
    localparam logic [3:0] S_APP_TAIL = 4'd6;
    localparam logic [3:0] S_RESP     = 4'd7;

    logic [3:0] state_reg, state_next;

    // configuration registers
    logic [ADDR_W-1:0]  base_cfg_reg, base_cfg_next;
    logic [ADDR_W-1:0]  len_cfg_reg, len_cfg_next;
    logic [BSIZE_W-1:0] bsize_cfg_reg, bsize_cfg_next;
    logic               force_cfg_reg, force_cfg_next;

    // pool state
    logic [CNT_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   free_reg, free_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic               exists_reg, exists_next;
    logic [ADDR_W-1:0]  pool_base_reg, pool_base_next;
    logic [BSIZE_W-1:0] pool_bsize_reg, pool_bsize_next;
    logic               pool_force_reg, pool_force_next;

    // sequencer working registers
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   link_cnt_reg, link_cnt_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   cur_reg, cur_next;
    logic [CNT_W-1:0]   steps_reg, steps_next;
    logic [ADDR_W-1:0]  prod_reg, prod_next;

    // result registers
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [CNT_W-1:0]    out_free_reg, out_free_next;
    logic [CNT_W-1:0]    out_used_reg, out_used_next;

    // link memory ports
    logic              ram_wr_en;
    logic [RAM_AW-1:0] ram_wr_addr;
    logic [CNT_W-1:0]  ram_wr_data;
    logic              ram_rd_en;
    logic [RAM_AW-1:0] ram_rd_addr;
    logic [CNT_W-1:0]  ram_rd_data;

    // divider ports
    logic               div_start;
    logic [ADDR_W-1:0]  div_dividend;
    logic [BSIZE_W-1:0] div_divisor;
    div_res_t           div_res;

    // helpers
    logic               create_commit;
    logic [CNT_W-1:0]   commit_n;
    logic [CNT_W-1:0]   link_plus1;
    logic [CNT_W-1:0]   n_sat;
    logic [ADDR_W-1:0]  mul_head;

    fbpa_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    fbpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    // handshakes
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{OUT_PAD{1'b0}}, out_used_reg, out_free_reg, out_addr_reg,
                        out_status_reg};

    // address offset of the head block, cut to 32 bits
    assign mul_head   = ADDR_W'(head_reg) * ADDR_W'(pool_bsize_reg);
    assign link_plus1 = link_cnt_reg + CNT_W'(1);
    assign n_sat      = (div_res.quotient > ADDR_W'(MAX_BLOCKS)) ? NULL_IDX
                                                                 : div_res.quotient[CNT_W-1:0];

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        base_cfg_next   = base_cfg_reg;
        len_cfg_next    = len_cfg_reg;
        bsize_cfg_next  = bsize_cfg_reg;
        force_cfg_next  = force_cfg_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_next       = free_reg;
        used_next       = used_reg;
        total_next      = total_reg;
        exists_next     = exists_reg;
        pool_base_next  = pool_base_reg;
        pool_bsize_next = pool_bsize_reg;
        pool_force_next = pool_force_reg;
        cmd_next        = cmd_reg;
        n_next          = n_reg;
        link_cnt_next   = link_cnt_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_free_next   = out_free_reg;
        out_used_next   = out_used_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = '0;
        ram_wr_data     = '0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;
        div_start       = 1'b0;
        div_dividend    = '0;
        div_divisor     = '0;
        create_commit   = 1'b0;
        commit_n        = n_reg;

        // configuration write transaction
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS: base_cfg_next  = cfg_data;
                CFG_POOL_LENGTH:  len_cfg_next   = cfg_data;
                CFG_BLOCK_SIZE:   bsize_cfg_next = cfg_data[BSIZE_W-1:0];
                CFG_FORCE_DELETE: force_cfg_next = cfg_data[0];
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next      = s_tuser;
                    res_addr_next = '0;
                    state_next    = S_RESP;
                    unique case (s_tuser)
                        CMD_CREATE:
                        begin
                            if (bsize_cfg_reg[0] || bsize_cfg_reg < MIN_BLOCK_SIZE)
                            begin
                                res_status_next = ST_BAD_SIZE;
                            end
                            else
                            begin
                                div_start    = 1'b1;
                                div_dividend = len_cfg_reg;
                                div_divisor  = bsize_cfg_reg;
                                state_next   = S_DIV;
                            end
                        end
                        CMD_GET:
                        begin
                            if (!exists_reg)
                            begin
                                res_status_next = ST_NO_POOL;
                            end
                            else if (head_reg >= NULL_IDX)
                            begin
                                res_status_next = ST_NONE_FREE;
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = head_reg[RAM_AW-1:0];
                                prod_next   = mul_head;
                                state_next  = S_GET_RD;
                            end
                        end
                        CMD_RELEASE:
                        begin
                            if (!exists_reg)
                            begin
                                res_status_next = ST_NO_POOL;
                            end
                            else if (s_tdata < pool_base_reg)
                            begin
                                res_status_next = ST_BAD_ADDR;
                            end
                            else
                            begin
                                div_start    = 1'b1;
                                div_dividend = s_tdata - pool_base_reg;
                                div_divisor  = pool_bsize_reg;
                                state_next   = S_DIV;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (!exists_reg)
                            begin
                                res_status_next = ST_NO_POOL;
                            end
                            else if (!pool_force_reg && used_reg != '0)
                            begin
                                res_status_next = ST_IN_USE;
                            end
                            else
                            begin
                                res_status_next = ST_OK;
                                head_next       = NULL_IDX;
                                tail_next       = NULL_IDX;
                                free_next       = '0;
                                used_next       = '0;
                                total_next      = '0;
                                exists_next     = 1'b0;
                                pool_base_next  = '0;
                                pool_bsize_next = '0;
                                pool_force_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    if (cmd_reg == CMD_CREATE)
                    begin
                        n_next        = n_sat;
                        link_cnt_next = '0;
                        if (n_sat == '0)
                        begin
                            create_commit = 1'b1;
                            commit_n      = n_sat;
                        end
                        else
                        begin
                            state_next = S_LINK;
                        end
                    end
                    else if (div_res.quotient >= ADDR_W'(total_reg) ||
                             div_res.remainder != '0)
                    begin
                        res_status_next = ST_BAD_ADDR;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        idx_next   = div_res.quotient[CNT_W-1:0];
                        cur_next   = head_reg;
                        steps_next = '0;
                        state_next = S_WALK;
                    end
                end
            end
            S_LINK:
            begin
                // chain the blocks in ascending order, last one ends the list
                ram_wr_en   = 1'b1;
                ram_wr_addr = link_cnt_reg[RAM_AW-1:0];
                ram_wr_data = (link_plus1 < n_reg) ? link_plus1 : NULL_IDX;
                if (link_plus1 == n_reg)
                begin
                    create_commit = 1'b1;
                end
                else
                begin
                    link_cnt_next = link_plus1;
                end
            end
            S_GET_RD:
            begin
                head_next       = (ram_rd_data >= NULL_IDX) ? NULL_IDX : ram_rd_data;
                free_next       = (free_reg != '0) ? free_reg - CNT_W'(1) : free_reg;
                used_next       = used_reg + CNT_W'(1);
                res_addr_next   = pool_base_reg + prod_reg;
                res_status_next = ST_OK;
                state_next      = S_RESP;
            end
            S_WALK:
            begin
                // double free search over the free list
                if (steps_reg < total_reg && cur_reg < NULL_IDX)
                begin
                    if (cur_reg == idx_reg)
                    begin
                        res_status_next = ST_ALREADY_FREE;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = cur_reg[RAM_AW-1:0];
                        state_next  = S_WALK_RD;
                    end
                end
                else
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = idx_reg[RAM_AW-1:0];
                    ram_wr_data = NULL_IDX;
                    if (head_reg >= NULL_IDX || tail_reg >= NULL_IDX)
                    begin
                        head_next       = idx_reg;
                        tail_next       = idx_reg;
                        free_next       = free_reg + CNT_W'(1);
                        used_next       = (used_reg != '0) ? used_reg - CNT_W'(1) : used_reg;
                        res_status_next = ST_OK;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_APP_TAIL;
                    end
                end
            end
            S_WALK_RD:
            begin
                cur_next   = ram_rd_data;
                steps_next = steps_reg + CNT_W'(1);
                state_next = S_WALK;
            end
            S_APP_TAIL:
            begin
                ram_wr_en       = 1'b1;
                ram_wr_addr     = tail_reg[RAM_AW-1:0];
                ram_wr_data     = idx_reg;
                tail_next       = idx_reg;
                free_next       = free_reg + CNT_W'(1);
                used_next       = (used_reg != '0) ? used_reg - CNT_W'(1) : used_reg;
                res_status_next = ST_OK;
                state_next      = S_RESP;
            end
            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_free_next   = free_reg;
                    out_used_next   = used_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // new pool takes over once its links are in place
        if (create_commit)
        begin
            head_next       = (commit_n != '0) ? '0 : NULL_IDX;
            tail_next       = (commit_n != '0) ? commit_n - CNT_W'(1) : NULL_IDX;
            free_next       = commit_n;
            used_next       = '0;
            total_next      = commit_n;
            exists_next     = 1'b1;
            pool_base_next  = base_cfg_reg;
            pool_bsize_next = bsize_cfg_reg;
            pool_force_next = force_cfg_reg;
            res_status_next = ST_OK;
            state_next      = S_RESP;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            base_cfg_reg   <= RST_BASE_ADDRESS;
            len_cfg_reg    <= RST_POOL_LENGTH;
            bsize_cfg_reg  <= RST_BLOCK_SIZE;
            force_cfg_reg  <= 1'b0;
            head_reg       <= NULL_IDX;
            tail_reg       <= NULL_IDX;
            free_reg       <= '0;
            used_reg       <= '0;
            total_reg      <= '0;
            exists_reg     <= 1'b0;
            pool_base_reg  <= '0;
            pool_bsize_reg <= '0;
            pool_force_reg <= 1'b0;
            cmd_reg        <= CMD_CREATE;
            n_reg          <= '0;
            link_cnt_reg   <= '0;
            idx_reg        <= '0;
            cur_reg        <= NULL_IDX;
            steps_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_cfg_reg   <= base_cfg_next;
            len_cfg_reg    <= len_cfg_next;
            bsize_cfg_reg  <= bsize_cfg_next;
            force_cfg_reg  <= force_cfg_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_reg       <= free_next;
            used_reg       <= used_next;
            total_reg      <= total_next;
            exists_reg     <= exists_next;
            pool_base_reg  <= pool_base_next;
            pool_bsize_reg <= pool_bsize_next;
            pool_force_reg <= pool_force_next;
            cmd_reg        <= cmd_next;
            n_reg          <= n_next;
            link_cnt_reg   <= link_cnt_next;
            idx_reg        <= idx_next;
            cur_reg        <= cur_next;
            steps_reg      <= steps_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_free_reg   <= out_free_next;
        out_used_reg   <= out_used_next;
    end

`ifndef NO_ASSERTIONS
    // every block of a live pool is either free or allocated
    assert property (@(posedge clk) disable iff (!rst_n)
        exists_reg |-> ({1'b0, free_reg} + {1'b0, used_reg}) == {1'b0, total_reg})
        else $error("free plus used count differs from pool size");

    // without a pool the list and the counters are empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !exists_reg |-> (free_reg == '0 && used_reg == '0 && head_reg == NULL_IDX))
        else $error("counters or list head set while no pool exists");

    // an accepted command always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg != S_IDLE)
        else $error("accepted command did not start the sequencer");

    // divider results only arrive while the sequencer waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");
`endif

endmodule
